FILE: sv/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

	// default screen geometry
	localparam int TCW_COLUMNS = 80;
	localparam int TCW_ROWS    = 25;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] BLANK_CODE   = 8'h20;
	localparam logic [7:0] RESET_ATTR   = 8'h0A;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		CMD_PUT,
		CMD_NEWLINE,
		CMD_CLEAR,
		CMD_READ,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] char_code;
		logic [7:0] attribute;
		logic [4:0] row;
		logic [6:0] col;
	} cmd_t;

	typedef struct packed {
		logic [15:0] cell_entry;
		logic [4:0]  pos_row;
		logic [6:0]  pos_col;
		logic        scrolled;
	} result_t;

	typedef enum logic [1:0] {
		ST_FILL,
		ST_IDLE,
		ST_READ
	} back_state_t;

endpackage

`default_nettype wire

FILE: sv/tcw_ram.sv
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

FILE: sv/tcw_front.sv
`default_nettype none

module tcw_front
	import tcw_pkg::*;
#(
	parameter int COLUMNS = TCW_COLUMNS,
	parameter int ROWS    = TCW_ROWS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       enable,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] opcode,
	input  wire logic [7:0] char_code,
	input  wire logic [7:0] attribute,
	input  wire logic [4:0] cell_row,
	input  wire logic [6:0] cell_col,
	output logic            cmd_valid,
	input  wire logic       cmd_ready,
	output cmd_t            cmd
);

	logic      valid_s1;
	cmd_t      cmd_s1;
	cmd_kind_t kind;
	logic      in_range;
	logic      take;

	assign in_range = (int'(cell_row) < ROWS) && (int'(cell_col) < COLUMNS);

	always_comb begin
		unique case (opcode_t'(opcode))
			OP_PUT:   kind = (char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT;
			OP_CLEAR: kind = CMD_CLEAR;
			OP_READ:  kind = in_range ? CMD_READ : CMD_NOP;
			OP_NOP:   kind = CMD_NOP;
		endcase
	end

	assign in_ready  = enable && (!valid_s1 || cmd_ready);
	assign take      = in_valid && in_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= '{kind: kind, char_code: char_code, attribute: attribute,
				row: cell_row, col: cell_col};
		end
	end

endmodule

`default_nettype wire

FILE: sv/tcw_fifo.sv
`default_nettype none

module tcw_fifo
	import tcw_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire cmd_t in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      out_data
);

	localparam logic [QPTR_W-1:0] LAST_SLOT = QPTR_W'(QUEUE_DEPTH - 1);
	localparam logic [QPTR_W:0]   FULL_CNT  = (QPTR_W + 1)'(QUEUE_DEPTH);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign in_ready  = (count_q != FULL_CNT);
	assign out_valid = (count_q != '0);
	assign out_data  = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

`default_nettype wire

FILE: sv/tcw_back.sv
`default_nettype none

module tcw_back
	import tcw_pkg::*;
#(
	parameter int COLUMNS = TCW_COLUMNS,
	parameter int ROWS    = TCW_ROWS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	input  wire cmd_t cmd,
	output logic      init_done,
	output logic      res_valid,
	input  wire logic res_ready,
	output result_t   res
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int AW    = $clog2(CELLS);

	localparam logic [RW:0]    ROWS_X    = (RW + 1)'(ROWS);
	localparam logic [RW-1:0]  LAST_ROW  = RW'(ROWS - 1);
	localparam logic [CW:0]    COLS_X    = (CW + 1)'(COLUMNS);
	localparam logic [AW-1:0]  COLS_A    = AW'(COLUMNS);
	localparam logic [AW-1:0]  LAST_COLA = AW'(COLUMNS - 1);
	localparam logic [AW-1:0]  LAST_CELL = AW'(CELLS - 1);

	back_state_t   state_q, state_d;
	logic [RW-1:0] cur_row_q;
	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] base_q;
	logic [AW-1:0] sweep_q;
	logic [AW-1:0] end_q;
	logic [7:0]    fill_attr_q;
	logic          init_done_q;
	logic          res_valid_q;
	result_t       res_q;

	logic          pop;
	logic          is_read;
	logic [RW-1:0] sel_row;
	logic [CW-1:0] sel_col;
	logic [RW:0]   phys_sum;
	logic [RW-1:0] phys_row;
	logic [AW-1:0] cell_addr;
	logic [AW-1:0] bottom_addr;
	logic [CW:0]   col_inc;
	logic [RW:0]   row_inc;
	logic [RW:0]   base_inc;
	logic          advance;
	logic          scroll;
	logic [RW-1:0] nxt_row;
	logic [CW-1:0] nxt_col;
	logic          fill_end;
	logic          load;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [15:0]   wr_data;
	logic [15:0]   rd_data;

	// logical row plus rotation base gives the physical row
	assign is_read   = (cmd.kind == CMD_READ);
	assign sel_row   = is_read ? RW'(cmd.row) : cur_row_q;
	assign sel_col   = is_read ? CW'(cmd.col) : cur_col_q;
	assign phys_sum  = {1'b0, sel_row} + {1'b0, base_q};
	assign phys_row  = (phys_sum >= ROWS_X) ? RW'(phys_sum - ROWS_X) : phys_sum[RW-1:0];
	assign cell_addr = AW'(phys_row) * COLS_A + AW'(sel_col);

	// old top row becomes the new bottom row on scroll
	assign bottom_addr = AW'(base_q) * COLS_A;
	assign base_inc    = {1'b0, base_q} + 1'b1;

	// cursor advance
	assign col_inc = {1'b0, cur_col_q} + 1'b1;
	assign row_inc = {1'b0, cur_row_q} + 1'b1;
	assign advance = (cmd.kind == CMD_NEWLINE) || (col_inc == COLS_X);
	assign scroll  = advance && (row_inc == ROWS_X);

	always_comb begin
		nxt_row = cur_row_q;
		nxt_col = cur_col_q;
		unique case (cmd.kind)
			CMD_PUT, CMD_NEWLINE: begin
				nxt_col = advance ? '0 : col_inc[CW-1:0];
				if (scroll) begin
					nxt_row = LAST_ROW;
				end else if (advance) begin
					nxt_row = row_inc[RW-1:0];
				end
			end
			CMD_CLEAR: begin
				nxt_row = '0;
				nxt_col = '0;
			end
			CMD_READ, CMD_NOP: begin
			end
			default: begin
			end
		endcase
	end

	assign fill_end = (sweep_q == end_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_FILL: begin
				if (fill_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (pop) begin
					if (is_read) begin
						state_d = ST_READ;
					end else if (cmd.kind == CMD_CLEAR) begin
						state_d = ST_FILL;
					end else if ((cmd.kind == CMD_PUT || cmd.kind == CMD_NEWLINE) && scroll) begin
						state_d = ST_FILL;
					end
				end
			end
			ST_READ: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop     = 1'b0;
		wr_en   = 1'b0;
		wr_addr = cell_addr;
		wr_data = {cmd.attribute, cmd.char_code};
		load    = 1'b0;
		unique case (state_q)
			ST_FILL: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
				wr_data = {fill_attr_q, BLANK_CODE};
			end
			ST_IDLE: begin
				pop   = cmd_valid && (!res_valid_q || res_ready);
				wr_en = pop && (cmd.kind == CMD_PUT);
				load  = pop && !is_read;
			end
			ST_READ: load = 1'b1;
			default: begin
			end
		endcase
	end

	assign cmd_ready = pop;
	assign init_done = init_done_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			base_q      <= '0;
			sweep_q     <= '0;
			end_q       <= LAST_CELL;
			fill_attr_q <= RESET_ATTR;
			init_done_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FILL && fill_end) begin
				init_done_q <= 1'b1;
			end
			if (pop) begin
				cur_row_q <= nxt_row;
				cur_col_q <= nxt_col;
			end
			priority if (pop && cmd.kind == CMD_CLEAR) begin
				sweep_q     <= '0;
				end_q       <= LAST_CELL;
				fill_attr_q <= cmd.attribute;
			end else if (pop && (cmd.kind == CMD_PUT || cmd.kind == CMD_NEWLINE) && scroll) begin
				sweep_q     <= bottom_addr;
				end_q       <= bottom_addr + LAST_COLA;
				fill_attr_q <= cmd.attribute;
				base_q      <= (base_inc == ROWS_X) ? '0 : base_inc[RW-1:0];
			end else if (state_q == ST_FILL && !fill_end) begin
				sweep_q <= sweep_q + 1'b1;
			end else begin
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// a read reports the cursor as it stands, everything else the updated cursor
	always_ff @(posedge clk) begin
		if (load) begin
			res_q.cell_entry <= (state_q == ST_READ) ? rd_data : 16'h0000;
			res_q.pos_row    <= (state_q == ST_READ) ? 5'(cur_row_q) : 5'(nxt_row);
			res_q.pos_col    <= (state_q == ST_READ) ? 7'(cur_col_q) : 7'(nxt_col);
			res_q.scrolled   <= (state_q == ST_IDLE) &&
				(cmd.kind == CMD_PUT || cmd.kind == CMD_NEWLINE) && scroll;
		end
	end

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_screen (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(cell_addr),
		.rd_data(rd_data)
	);

endmodule

`default_nettype wire

FILE: sv/text_console_writer.sv
`default_nettype none

// text console writer: keeps a ROWS x COLUMNS screen of 16-bit cells (character in the low
// byte, attribute in the high byte) and a cursor, and returns exactly one result word per
// input word. put writes the cell at the cursor and advances, wrapping at the right edge;
// char 0x0A is a newline; running past the bottom row scrolls up one row and blanks the new
// bottom row in the word's attribute. clear blanks the screen and homes the cursor; read
// returns one cell (zero if out of range). a front stage decodes each word into a command and
// hands it through a two-entry queue to the back end, which owns the screen ram and cursor.
// in the back end, read passes through a state for the registered ram read, a scroll blanks
// only the new bottom row (rows are rotated by a base pointer rather than copied), and clear
// blanks every cell, one ram write per cell through the single write port. after reset a
// clearing pass fills the screen with spaces in attribute 0x0A; no word is accepted until it
// is done.
module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = TCW_COLUMNS,
	parameter int ROWS    = TCW_ROWS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input words
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // char_code[7:0], attribute[15:8], cell_row[20:16],
	                                        // cell_col[27:21], zero[31:28]
	input  wire logic [1:0]  s_axis_tuser,  // opcode[1:0]
	// result words
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata   // cell_entry[15:0], cursor_row_out[20:16],
	                                        // cursor_col_out[27:21], scrolled[28], zero[31:29]
);

	// front to queue
	logic    front_valid;
	logic    front_ready;
	cmd_t    front_cmd;
	// queue to back
	logic    q_valid;
	logic    q_ready;
	cmd_t    q_cmd;
	// back status and result
	logic    init_done;
	result_t res;

	// decode stage, held off until the power-up clearing pass is done
	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.enable   (init_done),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.opcode   (s_axis_tuser),
		.char_code(s_axis_tdata[7:0]),
		.attribute(s_axis_tdata[15:8]),
		.cell_row (s_axis_tdata[20:16]),
		.cell_col (s_axis_tdata[27:21]),
		.cmd_valid(front_valid),
		.cmd_ready(front_ready),
		.cmd      (front_cmd)
	);

	// lets decode keep going while the back end sweeps the screen
	tcw_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (front_valid),
		.in_ready (front_ready),
		.in_data  (front_cmd),
		.out_valid(q_valid),
		.out_ready(q_ready),
		.out_data (q_cmd)
	);

	// screen ram, cursor, scroll and clear sequencing, result register
	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(q_valid),
		.cmd_ready(q_ready),
		.cmd      (q_cmd),
		.init_done(init_done),
		.res_valid(m_axis_tvalid),
		.res_ready(m_axis_tready),
		.res      (res)
	);

	assign m_axis_tdata = {3'b000, res.scrolled, res.pos_col, res.pos_row, res.cell_entry};

endmodule

`default_nettype wire
